[rtl/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared types and constants for the gradient palette generator: colour
// packing, step count limits, front-to-back commands and result items.
// ----------------------------------------------------------------------------
package gpg_pkg;

  localparam int COLOR_W   = 24;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int STEP_W    = 6;
  localparam int MAX_STEPS = 63;

  localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(16);
  localparam logic [STEP_W-1:0] MIN_STEPS   = STEP_W'(2);

  // command kinds passed from the front to the back
  typedef enum logic {
    CMD_ERR = 1'b0,
    CMD_SEG = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
    logic               fin;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               run_last;
    logic               palette_end;
    logic               too_few_colors;
  } res_t;

endpackage

[rtl/gpg_front.sv]
// ----------------------------------------------------------------------------
// gpg_front
// Accepts base colours, keeps the previous base colour and turns each item
// into a segment command, an error command or nothing (first colour).
// ----------------------------------------------------------------------------
module gpg_front import gpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [COLOR_W-1:0] base_color,
  input  logic               final_color,
  output logic               cmd_push,
  output cmd_t               cmd_data,
  input  logic               cmd_full
);

  logic [COLOR_W-1:0] prev_base;
  logic               have_prev;
  logic               accept;

  // item accepted whenever the command queue has room
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // classify: first colour is only stored, lone final colour is an error
  assign cmd_push      = accept && (have_prev || final_color);
  assign cmd_data.kind = have_prev ? CMD_SEG : CMD_ERR;
  assign cmd_data.c1   = prev_base;
  assign cmd_data.c2   = base_color;
  assign cmd_data.fin  = final_color;

  // previous base colour tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_base <= '0;
      have_prev <= 1'b0;
    end else if (accept) begin
      if (final_color) begin
        prev_base <= '0;
        have_prev <= 1'b0;
      end else begin
        prev_base <= base_color;
        have_prev <= 1'b1;
      end
    end
  end

endmodule

[rtl/gpg_cmd_queue.sv]
// ----------------------------------------------------------------------------
// gpg_cmd_queue
// Two-entry queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module gpg_cmd_queue import gpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

[rtl/gpg_back.sv]
// ----------------------------------------------------------------------------
// gpg_back
// Carries out commands: divides each channel difference once per segment,
// then walks the steps with a running quotient and remainder, drops
// repeated colours, and queues result items with end and error markers.
// ----------------------------------------------------------------------------
module gpg_back import gpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [STEP_W-1:0]  cfg_data,
  input  cmd_t               cmd_data,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output logic [COLOR_W-1:0] color,
  output logic               run_last,
  output logic               palette_end,
  output logic               too_few_colors
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STEP,
    S_FLUSH,
    S_MARK,
    S_ERR
  } state_t;

  state_t             state;
  logic [STEP_W-1:0]  steps;
  logic [STEP_W-1:0]  den;
  logic [STEP_W-1:0]  j_cnt;
  logic [2:0]         div_cnt;
  logic [COLOR_W-1:0] c1;
  logic               fin;

  // per-channel divider and stepping registers
  logic [CH_W-1:0]    dvd  [NUM_CH];
  logic [STEP_W-1:0]  rmd  [NUM_CH];
  logic [CH_W-1:0]    q    [NUM_CH];
  logic [STEP_W-1:0]  r    [NUM_CH];
  logic               neg  [NUM_CH];

  logic [COLOR_W-1:0] last_emitted;
  logic               have_emitted;
  logic [COLOR_W-1:0] held;
  logic               held_valid;

  // result queue
  res_t               out_mem [2];
  logic               out_wr;
  logic               out_rd;
  logic [1:0]         out_count;
  logic               out_push;
  res_t               out_item;
  logic               out_pop;
  logic               can_push;

  logic [COLOR_W-1:0] cur_color;
  logic               dup;
  logic               step_go;
  logic [STEP_W-1:0]  den_next;
  logic [STEP_W:0]    div_t    [NUM_CH];
  logic               div_ge   [NUM_CH];
  logic [STEP_W:0]    r_sum    [NUM_CH];
  logic               r_ge     [NUM_CH];
  logic [CH_W-1:0]    c1_ch    [NUM_CH];
  logic [CH_W-1:0]    c2_ch    [NUM_CH];

  // step count register
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= STEPS_RESET;
    end else if (cfg_write) begin
      steps <= cfg_data;
    end
  end

  // clamped divisor: steps minus one
  always_comb begin
    if (steps < MIN_STEPS) begin
      den_next = MIN_STEPS - STEP_W'(1);
    end else if (32'(steps) > MAX_STEPS) begin
      den_next = STEP_W'(MAX_STEPS - 1);
    end else begin
      den_next = steps - STEP_W'(1);
    end
  end

  // per-lane divider step, remainder update and current colour
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      c1_ch[k]  = c1[k*CH_W +: CH_W];
      c2_ch[k]  = cmd_data.c2[k*CH_W +: CH_W];
      div_t[k]  = {rmd[k], dvd[k][CH_W-1]};
      div_ge[k] = (div_t[k] >= {1'b0, den});
      r_sum[k]  = {1'b0, r[k]} + {1'b0, rmd[k]};
      r_ge[k]   = (r_sum[k] >= {1'b0, den});
      cur_color[k*CH_W +: CH_W] = neg[k] ? (c1_ch[k] - q[k]) : (c1_ch[k] + q[k]);
    end
  end

  assign dup      = have_emitted && (cur_color == last_emitted);
  assign can_push = (out_count != 2'd2);
  assign step_go  = dup || !held_valid || can_push;
  assign cmd_pop  = (state == S_IDLE) && !cmd_empty;

  // result selection per state
  always_comb begin
    out_push = 1'b0;
    out_item = '0;
    case (state)
      S_STEP: begin
        out_item.color = held;
        out_push       = !dup && held_valid && can_push;
      end
      S_FLUSH: begin
        out_item.color    = held;
        out_item.run_last = !fin;
        out_push          = held_valid && can_push;
      end
      S_MARK: begin
        out_item.run_last    = 1'b1;
        out_item.palette_end = 1'b1;
        out_push             = can_push;
      end
      S_ERR: begin
        out_item.run_last       = 1'b1;
        out_item.too_few_colors = 1'b1;
        out_push                = can_push;
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      last_emitted <= '0;
      have_emitted <= 1'b0;
      held_valid   <= 1'b0;
      held         <= '0;
      den          <= '0;
      j_cnt        <= '0;
      div_cnt      <= '0;
      c1           <= '0;
      fin          <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            c1      <= cmd_data.c1;
            fin     <= cmd_data.fin;
            den     <= den_next;
            div_cnt <= '0;
            j_cnt   <= '0;
            state   <= (cmd_data.kind == CMD_SEG) ? S_DIV : S_ERR;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'(CH_W - 1)) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_go) begin
            if (!dup) begin
              held         <= cur_color;
              held_valid   <= 1'b1;
              last_emitted <= cur_color;
              have_emitted <= 1'b1;
            end
            j_cnt <= j_cnt + STEP_W'(1);
            if (j_cnt == den) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!held_valid || can_push) begin
            held_valid <= 1'b0;
            state      <= fin ? S_MARK : S_IDLE;
          end
        end
        S_MARK: begin
          if (can_push) begin
            last_emitted <= '0;
            have_emitted <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_ERR: begin
          if (can_push) begin
            last_emitted <= '0;
            have_emitted <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-lane datapath: restoring divide, then running quotient and remainder
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (state == S_IDLE) begin
        neg[k] <= (c2_ch[k] < cmd_data.c1[k*CH_W +: CH_W]);
        dvd[k] <= (c2_ch[k] < cmd_data.c1[k*CH_W +: CH_W]) ?
                  (cmd_data.c1[k*CH_W +: CH_W] - c2_ch[k]) :
                  (c2_ch[k] - cmd_data.c1[k*CH_W +: CH_W]);
        rmd[k] <= '0;
        q[k]   <= '0;
        r[k]   <= '0;
      end else if (state == S_DIV) begin
        if (div_ge[k]) begin
          rmd[k] <= STEP_W'(div_t[k] - {1'b0, den});
        end else begin
          rmd[k] <= div_t[k][STEP_W-1:0];
        end
        dvd[k] <= {dvd[k][CH_W-2:0], div_ge[k]};
      end else if (state == S_STEP && step_go) begin
        if (r_ge[k]) begin
          r[k] <= STEP_W'(r_sum[k] - {1'b0, den});
          q[k] <= q[k] + dvd[k] + CH_W'(1);
        end else begin
          r[k] <= r_sum[k][STEP_W-1:0];
          q[k] <= q[k] + dvd[k];
        end
      end
    end
  end

  // result queue storage
  assign out_pop = pop && (out_count != 2'd0);
  assign empty   = (out_count == 2'd0);

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_mem[out_wr] <= out_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (out_push) begin
        out_wr <= ~out_wr;
      end
      if (out_pop) begin
        out_rd <= ~out_rd;
      end
      out_count <= out_count + 2'(out_push) - 2'(out_pop);
    end
  end

  assign color          = out_mem[out_rd].color;
  assign run_last       = out_mem[out_rd].run_last;
  assign palette_end    = out_mem[out_rd].palette_end;
  assign too_few_colors = out_mem[out_rd].too_few_colors;

`ifndef SYNTHESIS
  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_count != 2'd3)
    else $error("result queue count out of range");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_valid)
    else $error("held colour left over at end of segment");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (j_cnt <= den))
    else $error("step index beyond segment");

  a_mark_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK && can_push) |=> (!have_emitted && state == S_IDLE))
    else $error("gradient state not cleared after end marker");
`endif

endmodule

[rtl/gradient_palette_generator_unit.sv]
// A stored first colour gives no result; an error item gives a single error result.
// A segment item is taken as a command, divided once per channel, walked step by step
// and flushed, adding the end marker on a final item; the next command waits until then.
// Each channel has its own stepper; a full result queue can stall it, repeats give no result.
// Reset (rst, synchronous) clears queues and gradient state and sets the step count to 16.
// ----------------------------------------------------------------------------
// gradient_palette_generator_unit
// Multi-stop linear RGB gradient: base colours in, interpolated palette
// entries out, with end marker and error result.
// ----------------------------------------------------------------------------
module gradient_palette_generator_unit import gpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [STEP_W-1:0]  cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [COLOR_W-1:0] base_color,
  input  logic               final_color,
  output logic               empty,
  input  logic               pop,
  output logic [COLOR_W-1:0] color,
  output logic               run_last,
  output logic               palette_end,
  output logic               too_few_colors
);

  logic cmd_push;
  cmd_t cmd_wr;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_rd;
  logic cmd_empty;

  // front: accept and classify items
  gpg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .base_color  (base_color),
    .final_color (final_color),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_wr),
    .cmd_full    (cmd_full)
  );

  // command queue between front and back
  gpg_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  // back: interpolation and result queue
  gpg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmd_data       (cmd_rd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .color          (color),
    .run_last       (run_last),
    .palette_end    (palette_end),
    .too_few_colors (too_few_colors)
  );

endmodule
